// ----- hw/rtl/mcrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrt_pkg
// Shared types and constants of the reload timer bank.
// ----------------------------------------------------------------------------
package mcrt_pkg;

    localparam int CMD_W    = 4;
    localparam int CH_W     = 4;
    localparam int TICKS_W  = 16;
    localparam int ACTIVE_W = 5;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 6;   // holds channel counts up to 63
    localparam int IDXF_W   = 5;   // channel index field, up to 32 channels
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_START_ALL   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART_ALL = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PAUSE       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PAUSE_ALL   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_STOP        = 4'd7;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL    = 4'd8;

    localparam logic REG_RELOAD_TICKS    = 1'b0;
    localparam logic REG_ACTIVE_CHANNELS = 1'b1;

    localparam logic [TICKS_W-1:0]  RELOAD_RESET = 16'h0001;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_RELOAD,
        OP_CLEAR,
        OP_STOP
    } op_t;

    typedef struct packed {
        logic              step;
        logic              clear_mask;
        logic              load_out;
        op_t               op;
        logic [IDXF_W-1:0] idx;
    } dp_cmd_t;

endpackage

// ----- hw/rtl/mcrt_datapath.sv -----
// ----------------------------------------------------------------------------
// mcrt_datapath
// Channel counter store, run bits, timeout mask and output payload register.
// One channel is updated per step.
// ----------------------------------------------------------------------------
module mcrt_datapath
    import mcrt_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dp_cmd,
    input  logic [TICKS_W-1:0] reload_ticks,
    output logic [MASK_W-1:0]  timeout_mask,
    output logic               any_timeout
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [TICKS_W-1:0]      cnt_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] run_reg;
    logic [MASK_W-1:0]       mask_reg;
    logic [MASK_W-1:0]       mask_next;
    logic [MASK_W-1:0]       tmask_reg;
    logic                    any_reg;

    logic [IDX_W-1:0]   idx;
    logic [TICKS_W-1:0] cur;
    logic [TICKS_W-1:0] dec;
    logic [TICKS_W-1:0] cnt_next;
    logic               run_next;
    logic               hit;

    assign idx = dp_cmd.idx[IDX_W-1:0];
    assign cur = cnt_reg[idx];
    assign dec = cur - 16'd1;

    always_comb
    begin
        cnt_next = cur;
        run_next = run_reg[idx];
        hit      = 1'b0;
        unique case (dp_cmd.op)
            OP_TICK:
            begin
                if (run_reg[idx] && (cur != '0))
                begin
                    if (dec == '0)
                    begin
                        hit      = 1'b1;
                        cnt_next = reload_ticks;
                    end
                    else
                    begin
                        cnt_next = dec;
                    end
                end
            end
            OP_START:
            begin
                cnt_next = reload_ticks;
                run_next = 1'b1;
            end
            OP_RELOAD:
            begin
                cnt_next = reload_ticks;
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            OP_STOP:
            begin
                cnt_next = '0;
                run_next = 1'b0;
            end
            default:
            begin
                cnt_next = cur;
            end
        endcase
    end

    // channels above the mask width count but never show in the mask
    always_comb
    begin
        mask_next = mask_reg;
        if (dp_cmd.clear_mask)
        begin
            mask_next = '0;
        end
        else if (dp_cmd.step && hit)
        begin
            for (int j = 0; j < MASK_W; j++)
            begin
                if ({{(CNT_W-IDXF_W){1'b0}}, dp_cmd.idx} == CNT_W'(j))
                begin
                    mask_next[j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            run_reg  <= '0;
            mask_reg <= '0;
        end
        else
        begin
            if (dp_cmd.step)
            begin
                cnt_reg[idx] <= cnt_next;
                run_reg[idx] <= run_next;
            end
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            tmask_reg <= mask_reg;
            any_reg   <= |mask_reg;
        end
    end

    assign timeout_mask = tmask_reg;
    assign any_timeout  = any_reg;

endmodule

// ----- hw/rtl/mcrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcrt_ctrl
// Command sequencer: accepts a transaction, walks the channels it covers one
// per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mcrt_ctrl
    import mcrt_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [CH_W-1:0]     channel,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [ACTIVE_W-1:0] active_channels,
    output dp_cmd_t             dp_cmd
);

    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_CHANNELS);

    state_t             state_reg;
    state_t             state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [CNT_W-1:0]   idx_cnt_reg;
    logic [CNT_W-1:0]   idx_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [CNT_W-1:0]   active_ext;
    logic [CNT_W-1:0]   ch_ext;
    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   len;
    logic               ch_ok;
    logic               all_cmd;
    op_t                op;
    logic               accept;

    assign active_ext = {{(CNT_W-ACTIVE_W){1'b0}}, active_channels};
    assign ch_ext     = {{(CNT_W-CH_W){1'b0}}, ch_reg};
    assign lim        = (active_ext > NUM_C) ? NUM_C : active_ext;
    assign ch_ok      = ch_ext < NUM_C;
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        op      = OP_TICK;
        all_cmd = 1'b1;
        len     = '0;
        unique case (cmd_reg)
            CMD_TICK:        begin op = OP_TICK;   len = lim; end
            CMD_START:       begin op = OP_START;  all_cmd = 1'b0; len = CNT_W'(ch_ok); end
            CMD_START_ALL:   begin op = OP_START;  len = lim; end
            CMD_RESTART:     begin op = OP_RELOAD; all_cmd = 1'b0; len = CNT_W'(ch_ok); end
            CMD_RESTART_ALL: begin op = OP_RELOAD; len = lim; end
            CMD_PAUSE:       begin op = OP_CLEAR;  all_cmd = 1'b0; len = CNT_W'(ch_ok); end
            CMD_PAUSE_ALL:   begin op = OP_CLEAR;  len = lim; end
            CMD_STOP:        begin op = OP_STOP;   all_cmd = 1'b0; len = CNT_W'(ch_ok); end
            CMD_STOP_ALL:    begin op = OP_STOP;   len = NUM_C; end
            default:         begin op = OP_TICK;   len = '0; end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_cnt_next      = idx_cnt_reg;
        out_valid_next    = out_valid_reg;
        dp_cmd.step       = 1'b0;
        dp_cmd.clear_mask = 1'b0;
        dp_cmd.load_out   = 1'b0;
        dp_cmd.op         = op;
        dp_cmd.idx        = all_cmd ? idx_cnt_reg[IDXF_W-1:0] : ch_ext[IDXF_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dp_cmd.clear_mask = 1'b1;
                    idx_cnt_next      = '0;
                    state_next        = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_cnt_reg < len)
                begin
                    dp_cmd.step  = 1'b1;
                    idx_cnt_next = idx_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.load_out = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_cnt_reg   <= idx_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            ch_reg  <= channel;
        end
    end

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_cnt_reg <= NUM_C)
        else $error("walk index beyond channel count");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.step |-> ({{(CNT_W-IDXF_W){1'b0}}, dp_cmd.idx} < NUM_C))
        else $error("counter step outside the bank");

    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK) && (idx_cnt_reg == '0))
        else $error("accepted transaction did not start a walk");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |=> out_valid_reg)
        else $error("result loaded without valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

// ----- hw/rtl/multi_channel_reload_timer_bank.sv -----
// ----------------------------------------------------------------------------
// multi_channel_reload_timer_bank
// Bank of auto-reload countdown timers with an APB register port.
// ----------------------------------------------------------------------------
// Each transaction returns one result. The counter store has a single update
// port and the sequencer visits one channel per cycle. A transaction covers as
// many channels as the active channel count (capped at NUM_CHANNELS) for tick,
// start all, restart all and pause all, NUM_CHANNELS for stop all, one for a
// single-channel command on a valid channel and none otherwise. A new
// transaction is taken only after the previous result has moved into the
// output register. Registers: reload_ticks at 0x0, active_channels at 0x4;
// write them only while the bank is idle.
// ----------------------------------------------------------------------------
module multi_channel_reload_timer_bank
    import mcrt_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [CH_W-1:0]    channel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MASK_W-1:0]  timeout_mask,
    output logic               any_timeout,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TICKS_W-1:0]  reload_ticks_reg;
    logic [ACTIVE_W-1:0] active_channels_reg;
    logic                cfg_wr;
    logic                reg_sel;
    dp_cmd_t             dp_cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_ticks_reg    <= RELOAD_RESET;
            active_channels_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_RELOAD_TICKS)
            begin
                reload_ticks_reg <= pwdata[TICKS_W-1:0];
            end
            else
            begin
                active_channels_reg <= pwdata[ACTIVE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_ACTIVE_CHANNELS)
        begin
            prdata = {{(PDATA_W-ACTIVE_W){1'b0}}, active_channels_reg};
        end
        else
        begin
            prdata = {{(PDATA_W-TICKS_W){1'b0}}, reload_ticks_reg};
        end
    end

    mcrt_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .channel         (channel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .active_channels (active_channels_reg),
        .dp_cmd          (dp_cmd)
    );

    mcrt_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .reload_ticks (reload_ticks_reg),
        .timeout_mask (timeout_mask),
        .any_timeout  (any_timeout)
    );

endmodule
